>>> rtl/core/afcd_pkg.sv
// ----------------------------------------------------------------------------
// afcd_pkg: shared types and constants
// Types, codes and constants for the animation frame command decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package afcd_pkg;

  localparam int unsigned ScreenBytesDef  = 64000;
  localparam int unsigned PaletteBytesDef = 768;
  localparam int unsigned QueueDepth      = 4;

  localparam logic [7:0] RunMask  = 8'hc0;
  localparam logic [7:0] CountMask = 8'h3f;

  typedef enum logic [4:0] {
    PH_HDR      = 5'd0,
    PH_OP       = 5'd1,
    PH_PAL_RAW  = 5'd2,
    PH_PAL_CTRL = 5'd3,
    PH_PAL_VAL  = 5'd4,
    PH_FILL     = 5'd5,
    PH_SCR_RAW  = 5'd6,
    PH_SCR_CTRL = 5'd7,
    PH_SCR_VAL  = 5'd8,
    PH_CNT_LO   = 5'd9,
    PH_CNT_HI   = 5'd10,
    PH_OFF_LO   = 5'd11,
    PH_OFF_HI   = 5'd12,
    PH_RUN      = 5'd13,
    PH_VAL      = 5'd14,
    PH_LIT      = 5'd15,
    PH_DONE     = 5'd16
  } phase_e;

  typedef enum logic [2:0] {
    KIND_FILL   = 3'd0,
    KIND_STAGE  = 3'd1,
    KIND_COMMIT = 3'd2,
    KIND_FRAME  = 3'd3,
    KIND_ENTRY  = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TRUNC    = 3'd1,
    ERR_OPCODE   = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_TRAILING = 3'd4
  } err_e;

  localparam logic [7:0] OP_NOP     = 8'd0;
  localparam logic [7:0] OP_PAL_RAW = 8'd1;
  localparam logic [7:0] OP_PAL_RLE = 8'd2;
  localparam logic [7:0] OP_FILL    = 8'd4;
  localparam logic [7:0] OP_SCR_RAW = 8'd5;
  localparam logic [7:0] OP_SCR_RLE = 8'd6;
  localparam logic [7:0] OP_POKE    = 8'd7;
  localparam logic [7:0] OP_RUNS    = 8'd8;
  localparam logic [7:0] OP_SPANS   = 8'd9;

  // One decoded step: an optional write and an optional status result.
  typedef struct packed {
    logic        w_has;
    kind_e       w_kind;
    logic [15:0] w_addr;
    logic [15:0] w_len;
    logic [7:0]  w_val;
    logic        e_has;
    kind_e       e_kind;
    err_e        e_code;
  } step_t;

endpackage

`default_nettype wire

>>> rtl/core/afcd_if.sv
// ----------------------------------------------------------------------------
// afcd_in_if / afcd_out_if: stream channels
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface afcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface afcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] address;
  logic [15:0] length;
  logic [7:0]  value;
  logic [2:0]  error_code;
  logic        last_of_input;
  modport source (output valid, kind, address, length, value, error_code, last_of_input,
                  input ready);
  modport sink (input valid, kind, address, length, value, error_code, last_of_input,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/afcd_front.sv
// ----------------------------------------------------------------------------
// afcd_front: byte parser
// Tracks frame and command phase per byte and emits one step record.
// ----------------------------------------------------------------------------
`default_nettype none

module afcd_front #(
  parameter int unsigned ScreenBytes  = 64000,
  parameter int unsigned PaletteBytes = 768
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [15:0]         frame_total_i,
  input  wire                 take_i,
  input  wire  [7:0]          byte_i,
  input  wire                 last_i,
  output logic                halted_o,
  output afcd_pkg::step_t     step_o
);
  import afcd_pkg::*;

  localparam logic [16:0] ScrB = 17'(ScreenBytes);
  localparam logic [16:0] PalB = 17'(PaletteBytes);

  phase_e      phase_q, phase_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [15:0] flen_q, flen_d, fused_q, fused_d, cmds_q, cmds_d;
  logic [3:0]  opc_q, opc_d;
  logic [9:0]  pidx_q, pidx_d;
  logic [15:0] sidx_q, sidx_d, ents_q, ents_d, toff_q, toff_d;
  logic [7:0]  run_q, run_d, lo_q, lo_d;
  logic [15:0] fdone_q, fdone_d;
  logic        fault_q, fault_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; hidx_q <= '0; flen_q <= '0; fused_q <= '0; cmds_q <= '0;
      opc_q <= '0; pidx_q <= '0; sidx_q <= '0; ents_q <= '0; toff_q <= '0;
      run_q <= '0; lo_q <= '0; fdone_q <= '0; fault_q <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d; hidx_q <= hidx_d; flen_q <= flen_d; fused_q <= fused_d;
      cmds_q <= cmds_d; opc_q <= opc_d; pidx_q <= pidx_d; sidx_q <= sidx_d;
      ents_q <= ents_d; toff_q <= toff_d; run_q <= run_d; lo_q <= lo_d;
      fdone_q <= fdone_d; fault_q <= fault_d;
    end
  end

  assign halted_o = fault_q || (phase_q == PH_DONE);

  always_comb begin
    logic        cdone;
    logic [16:0] sum;
    logic [16:0] n17;
    logic [15:0] fd1;
    logic        eend;
    phase_d = phase_q; hidx_d = hidx_q; flen_d = flen_q; fused_d = fused_q;
    cmds_d = cmds_q; opc_d = opc_q; pidx_d = pidx_q; sidx_d = sidx_q;
    ents_d = ents_q; toff_d = toff_q; run_d = run_q; lo_d = lo_q;
    fdone_d = fdone_q; fault_d = fault_q;
    step_o = '0;
    step_o.w_kind = KIND_FILL; step_o.e_kind = KIND_FILL; step_o.e_code = ERR_NONE;
    cdone = 1'b0; sum = '0; n17 = '0; eend = 1'b0;
    fd1 = fdone_q + 16'd1;

    if (phase_q == PH_HDR) begin
      hidx_d = hidx_q + 3'd1;
      unique case (hidx_q)
        3'd0: begin
          if (fdone_q >= frame_total_i) begin
            step_o.e_has = 1'b1; step_o.e_kind = KIND_ENTRY; phase_d = PH_DONE;
            hidx_d = hidx_q;
          end else flen_d = {8'd0, byte_i};
        end
        3'd1: flen_d = {byte_i, flen_q[7:0]};
        3'd2: cmds_d = {8'd0, byte_i};
        3'd3: cmds_d = {byte_i, cmds_q[7:0]};
        3'd7: begin
          hidx_d = '0; fused_d = '0;
          if (flen_q == 16'd0) begin
            if (cmds_q == 16'd0) begin
              fdone_d = fd1; step_o.e_has = 1'b1;
              if (fd1 >= frame_total_i) begin
                step_o.e_kind = KIND_ENTRY; phase_d = PH_DONE;
              end else begin
                step_o.e_kind = KIND_FRAME;
              end
            end else begin
              step_o.e_has = 1'b1; step_o.e_kind = KIND_ERROR; step_o.e_code = ERR_TRUNC;
              fault_d = 1'b1;
            end
          end else if (cmds_q == 16'd0) begin
            step_o.e_has = 1'b1; step_o.e_kind = KIND_ERROR; step_o.e_code = ERR_TRAILING;
            fault_d = 1'b1;
          end else phase_d = PH_OP;
        end
        default: ;
      endcase
    end else if (phase_q != PH_DONE) begin
      fused_d = fused_q + 16'd1;
      unique case (phase_q)
        PH_OP: begin
          case (byte_i)
            OP_NOP: cdone = 1'b1;
            OP_PAL_RAW: begin
              if ({1'b0, fused_d} + PalB > {1'b0, flen_q}) begin
                step_o.e_has = 1'b1; step_o.e_code = ERR_TRUNC; fault_d = 1'b1;
              end else begin
                pidx_d = '0; phase_d = PH_PAL_RAW;
              end
            end
            OP_PAL_RLE: begin pidx_d = '0; phase_d = PH_PAL_CTRL; end
            OP_FILL: phase_d = PH_FILL;
            OP_SCR_RAW: begin
              if ({1'b0, fused_d} + ScrB > {1'b0, flen_q}) begin
                step_o.e_has = 1'b1; step_o.e_code = ERR_TRUNC; fault_d = 1'b1;
              end else begin
                sidx_d = '0; phase_d = PH_SCR_RAW;
              end
            end
            OP_SCR_RLE: begin sidx_d = '0; phase_d = PH_SCR_CTRL; end
            OP_POKE, OP_RUNS, OP_SPANS: begin opc_d = byte_i[3:0]; phase_d = PH_CNT_LO; end
            default: begin
              step_o.e_has = 1'b1; step_o.e_code = ERR_OPCODE; fault_d = 1'b1;
            end
          endcase
        end
        PH_PAL_RAW, PH_PAL_CTRL, PH_PAL_VAL: begin
          if (phase_q == PH_PAL_CTRL && (byte_i & RunMask) == RunMask) begin
            if ({7'd0, pidx_q} + {11'd0, byte_i[5:0]} > PalB) begin
              step_o.e_has = 1'b1; step_o.e_code = ERR_OVERFLOW; fault_d = 1'b1;
            end else begin
              run_d = byte_i & CountMask; phase_d = PH_PAL_VAL;
            end
          end else if (phase_q == PH_PAL_VAL && run_q == 8'd0) begin
            phase_d = PH_PAL_CTRL;
          end else begin
            if (phase_q == PH_PAL_VAL) begin
              phase_d = PH_PAL_CTRL;
              pidx_d = pidx_q + {2'd0, run_q};
              step_o.w_len = {8'd0, run_q};
            end else begin
              pidx_d = pidx_q + 10'd1;
              step_o.w_len = 16'd1;
            end
            step_o.w_has = 1'b1; step_o.w_addr = {6'd0, pidx_q}; step_o.w_val = byte_i;
            cdone = ({7'd0, pidx_d} >= PalB);
            step_o.w_kind = cdone ? KIND_COMMIT : KIND_STAGE;
          end
        end
        PH_FILL: begin
          step_o.w_has = 1'b1; step_o.w_len = ScrB[15:0]; step_o.w_val = byte_i;
          cdone = 1'b1;
        end
        PH_SCR_RAW, PH_SCR_CTRL, PH_SCR_VAL: begin
          if (phase_q == PH_SCR_CTRL && (byte_i & RunMask) == RunMask) begin
            if ({1'b0, sidx_q} + {11'd0, byte_i[5:0]} > ScrB) begin
              step_o.e_has = 1'b1; step_o.e_code = ERR_OVERFLOW; fault_d = 1'b1;
            end else begin
              run_d = byte_i & CountMask; phase_d = PH_SCR_VAL;
            end
          end else if (phase_q == PH_SCR_VAL && run_q == 8'd0) begin
            phase_d = PH_SCR_CTRL;
          end else begin
            if (phase_q == PH_SCR_VAL) begin
              phase_d = PH_SCR_CTRL;
              sidx_d = sidx_q + {8'd0, run_q};
              step_o.w_len = {8'd0, run_q};
            end else begin
              sidx_d = sidx_q + 16'd1;
              step_o.w_len = 16'd1;
            end
            step_o.w_has = 1'b1; step_o.w_addr = sidx_q; step_o.w_val = byte_i;
            cdone = ({1'b0, sidx_d} >= ScrB);
          end
        end
        PH_CNT_LO: begin lo_d = byte_i; phase_d = PH_CNT_HI; end
        PH_CNT_HI: begin
          ents_d = {byte_i, lo_q};
          if (ents_d == 16'd0) cdone = 1'b1;
          else phase_d = PH_OFF_LO;
        end
        PH_OFF_LO: begin lo_d = byte_i; phase_d = PH_OFF_HI; end
        PH_OFF_HI: begin
          toff_d = {byte_i, lo_q};
          phase_d = (opc_q == OP_POKE[3:0]) ? PH_VAL : PH_RUN;
        end
        PH_RUN: begin
          run_d = byte_i;
          if (opc_q == OP_RUNS[3:0]) phase_d = PH_VAL;
          else if ({1'b0, fused_d} + {9'd0, byte_i} > {1'b0, flen_q}) begin
            step_o.e_has = 1'b1; step_o.e_code = ERR_TRUNC; fault_d = 1'b1;
          end else if (byte_i == 8'd0) eend = 1'b1;
          else phase_d = PH_LIT;
        end
        PH_VAL: begin
          if ({1'b0, toff_q} < ScrB) begin
            n17 = (opc_q == OP_POKE[3:0]) ? 17'd1 : {9'd0, run_q};
            sum = {1'b0, toff_q} + n17;
            if (sum > ScrB) n17 = ScrB - {1'b0, toff_q};
            if (n17 != 17'd0) begin
              step_o.w_has = 1'b1; step_o.w_addr = toff_q; step_o.w_len = n17[15:0];
              step_o.w_val = byte_i;
            end
          end
          eend = 1'b1;
        end
        PH_LIT: begin
          if ({1'b0, toff_q} < ScrB) begin
            step_o.w_has = 1'b1; step_o.w_addr = toff_q; step_o.w_len = 16'd1;
            step_o.w_val = byte_i;
          end
          if (toff_q != 16'hffff) toff_d = toff_q + 16'd1;
          run_d = run_q - 8'd1;
          if (run_d == 8'd0) eend = 1'b1;
        end
        default: ;
      endcase

      if (eend) begin
        ents_d = ents_q - 16'd1;
        if (ents_d == 16'd0) cdone = 1'b1;
        else phase_d = PH_OFF_LO;
      end

      if (step_o.e_has) step_o.e_kind = KIND_ERROR;
      else begin
        if (cdone) begin
          cmds_d = cmds_q - 16'd1;
          if (cmds_d == 16'd0) begin
            step_o.e_has = 1'b1;
            if (fused_d == flen_q) begin
              fdone_d = fd1;
              if (fd1 >= frame_total_i) begin
                step_o.e_kind = KIND_ENTRY; phase_d = PH_DONE;
              end else begin
                step_o.e_kind = KIND_FRAME; phase_d = PH_HDR; hidx_d = '0;
              end
            end else begin
              step_o.e_kind = KIND_ERROR; step_o.e_code = ERR_TRAILING; fault_d = 1'b1;
            end
          end else phase_d = PH_OP;
        end
        if (!step_o.e_has && fused_d >= flen_q) begin
          step_o.e_has = 1'b1; step_o.e_kind = KIND_ERROR; step_o.e_code = ERR_TRUNC;
          fault_d = 1'b1;
        end
      end
    end

    // Early end of the entry overrides a frame done.
    if (last_i && !fault_d && phase_d != PH_DONE) begin
      step_o.e_has = 1'b1; step_o.e_kind = KIND_ERROR; step_o.e_code = ERR_TRUNC;
      fault_d = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/afcd_queue.sv
// ----------------------------------------------------------------------------
// afcd_queue: step queue
// Small FIFO of step records between parser and result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module afcd_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  afcd_pkg::step_t  data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             empty_o,
  output afcd_pkg::step_t  data_o
);
  import afcd_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  step_t        mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/afcd_back.sv
// ----------------------------------------------------------------------------
// afcd_back: result sequencer
// Splits each step record into its one or two results on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module afcd_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               empty_i,
  input  afcd_pkg::step_t   step_i,
  output logic              pop_o,
  afcd_out_if.source        out_o
);
  import afcd_pkg::*;

  logic sent_w_q;  // write half already delivered
  logic do_w;

  assign do_w = step_i.w_has && !sent_w_q;

  always_comb begin
    out_o.valid = !empty_i;
    out_o.kind = do_w ? step_i.w_kind : step_i.e_kind;
    out_o.address = do_w ? step_i.w_addr : 16'd0;
    out_o.length  = do_w ? step_i.w_len : 16'd0;
    out_o.value   = do_w ? step_i.w_val : 8'd0;
    out_o.error_code = do_w ? ERR_NONE : ((step_i.e_kind == KIND_ERROR) ? step_i.e_code : ERR_NONE);
    out_o.last_of_input = do_w ? !step_i.e_has : 1'b1;
    pop_o = !empty_i && out_o.ready && !(do_w && step_i.e_has);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sent_w_q <= 1'b0;
    else if (!empty_i && out_o.ready) sent_w_q <= do_w && step_i.e_has;
  end

endmodule

`default_nettype wire

>>> rtl/core/animation_frame_command_decoder.sv
// ----------------------------------------------------------------------------
// animation_frame_command_decoder: animation frame byte stream decoder
// Turns the frames of an animation entry into screen fill and palette writes.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on in_i and never stalls while the
// internal queue has room. Each byte produces at most two results (one write,
// then a frame done, entry done or error); a byte with two results holds the
// output until both are taken, so sustained rate is one byte per cycle when bytes
// give one result or none, bounded by the output port at one result a cycle.
// Results of an accepted byte pass through the queue register to the output.
// After an error or entry done the block drops all further bytes until
// reset. Write frame_total_i only while idle.
`default_nettype none

module animation_frame_command_decoder #(
  parameter int unsigned ScreenBytes  = afcd_pkg::ScreenBytesDef,
  parameter int unsigned PaletteBytes = afcd_pkg::PaletteBytesDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  afcd_in_if.sink     in_i,
  afcd_out_if.source  out_o
);
  import afcd_pkg::*;

  logic [15:0] frame_total_q;
  logic        full, empty, pop, halted, take, push;
  step_t       step_f, step_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) frame_total_q <= '0;
    else if (cfg_we_i) frame_total_q <= cfg_wdata_i;
  end

  // Accept whenever the queue has room; halted bytes are dropped.
  assign in_i.ready = !full;
  assign take = in_i.valid && !full && !halted;
  assign push = take && (step_f.w_has || step_f.e_has);

  afcd_front #(.ScreenBytes(ScreenBytes), .PaletteBytes(PaletteBytes)) u_front (
    .clk_i, .rst_ni, .frame_total_i(frame_total_q), .take_i(take),
    .byte_i(in_i.data_byte), .last_i(in_i.last_byte), .halted_o(halted), .step_o(step_f)
  );

  afcd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(step_f), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(step_b)
  );

  afcd_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .step_i(step_b), .pop_o(pop), .out_o(out_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/afcd_checker.sv
// ----------------------------------------------------------------------------
// afcd_checker: port checks
// Assertions on the decoder's ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module afcd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  out_kind,
  input wire [2:0]  out_error_code,
  input wire [15:0] out_address,
  input wire        out_last
);
  import afcd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("result dropped while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_FRAME || out_kind == KIND_ENTRY || out_kind == KIND_ERROR)
    |-> out_last && out_address == 16'd0)
    else $error("status result malformed");

  a_write_noerr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_FILL || out_kind == KIND_STAGE || out_kind == KIND_COMMIT)
    |-> out_error_code == ERR_NONE)
    else $error("write carries error code");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> out_valid &&
    (out_kind == KIND_FRAME || out_kind == KIND_ENTRY || out_kind == KIND_ERROR))
    else $error("write not followed by status");

endmodule

bind animation_frame_command_decoder afcd_checker u_afcd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_kind(out_o.kind), .out_error_code(out_o.error_code),
  .out_address(out_o.address), .out_last(out_o.last_of_input)
);

`default_nettype wire
